[rtl/dvp_pkg.sv]
// dvp_pkg: shared constants for the dotted version parser
// character codes, configuration register indexes and field widths
// no dependencies
`default_nettype none

package dvp_pkg;

    // field widths
    localparam int CHAR_W    = 8;
    localparam int VAL_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 104;

    // character codes
    localparam logic [CHAR_W-1:0] CH_V    = 8'h76;
    localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MAJOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MINOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_PATCH = 2'd2;

    // component positions
    localparam logic [1:0] COMP_MAJOR = 2'd0;
    localparam logic [1:0] COMP_MINOR = 2'd1;
    localparam logic [1:0] COMP_PATCH = 2'd2;

    // digit count saturates here
    localparam logic [1:0] DIGITS_MANY = 2'd2;

endpackage : dvp_pkg

`default_nettype wire

[rtl/dotted_version_parser_core.sv]
// dotted_version_parser_core: streaming parser for "vMAJOR.MINOR.PATCH" strings
// depends on dvp_pkg for character codes and register indexes
// input word register, parse state update, result word register
`default_nettype none

// Takes one character word per cycle on the s_ side, with s_tlast on the final
// character of a version string. A leading 'v' is optional; then exactly three
// dot-separated decimal components are required, with no leading zeros and each
// fitting in 32 bits. On the final character one result word appears on the m_
// side: valid flag, major, minor, patch (all zero when invalid) and whether the
// version is strictly newer than the reference written through the cfg_ port.
// Throughput is one character per cycle except in the stall below; the result
// word passes through the input register, then the result register, and the
// only stall is a final character held in the input register while the
// previous result word waits on m_tready.
// The cfg_ registers may be written only while no string is in flight.
module dotted_version_parser_core
    import dvp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [VAL_W-1:0]     cfg_wdata,
    // character input
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [CHAR_W-1:0]    s_tdata,   // [7:0] char_in
    input  wire logic                 s_tlast,   // last_char
    // result output
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata    // [0] valid_res, [32:1] major_out,
                                                 // [64:33] minor_out, [96:65] patch_out,
                                                 // [97] newer, [103:98] zero
);

    // reference version registers
    logic [VAL_W-1:0] ref_major_reg;
    logic [VAL_W-1:0] ref_minor_reg;
    logic [VAL_W-1:0] ref_patch_reg;

    // input word register
    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;

    // parse state
    logic             at_start_reg,   at_start_next;
    logic [1:0]       comp_idx_reg,   comp_idx_next;
    logic [VAL_W-1:0] accum_reg,      accum_next;
    logic [1:0]       digit_cnt_reg,  digit_cnt_next;
    logic             first_zero_reg, first_zero_next;
    logic             err_reg,        err_next;
    logic [VAL_W-1:0] major_reg,      major_next;
    logic [VAL_W-1:0] minor_reg,      minor_next;

    // result word register
    logic             out_valid_reg, out_valid_next;
    logic             res_ok_reg;
    logic [VAL_W-1:0] res_major_reg;
    logic [VAL_W-1:0] res_minor_reg;
    logic [VAL_W-1:0] res_patch_reg;
    logic             res_newer_reg;

    logic proc;
    logic is_digit;
    logic [3:0] digit;
    logic [VAL_W+3:0] accum_ext;
    logic [VAL_W+3:0] prod;
    logic ovf;
    logic ok;
    logic newer;

    // handshake: the input register drains whenever the result side can take it
    assign proc     = in_valid_reg && (!last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;

    // multiply by ten plus digit, overflow shows in the top bits
    assign is_digit  = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign digit     = char_reg[3:0];
    assign accum_ext = {4'b0000, accum_reg};
    assign prod      = (accum_ext << 3) + (accum_ext << 1) + {{VAL_W{1'b0}}, digit};
    assign ovf       = |prod[VAL_W+3:VAL_W];

    // per-character parse update
    always_comb
    begin
        at_start_next   = at_start_reg;
        comp_idx_next   = comp_idx_reg;
        accum_next      = accum_reg;
        digit_cnt_next  = digit_cnt_reg;
        first_zero_next = first_zero_reg;
        err_next        = err_reg;
        major_next      = major_reg;
        minor_next      = minor_reg;
        if (proc)
        begin
            at_start_next = 1'b0;
            if (err_reg)
            begin
                // already invalid, ignore until the end
            end
            else if (at_start_reg && char_reg == CH_V)
            begin
                // optional leading v
            end
            else if (is_digit)
            begin
                if (digit_cnt_reg != 2'd0 && first_zero_reg)
                    err_next = 1'b1;
                else if (ovf)
                    err_next = 1'b1;
                else
                begin
                    accum_next = prod[VAL_W-1:0];
                    if (digit_cnt_reg == 2'd0)
                        first_zero_next = (digit == 4'd0);
                    if (digit_cnt_reg != DIGITS_MANY)
                        digit_cnt_next = digit_cnt_reg + 2'd1;
                end
            end
            else if (char_reg == CH_DOT)
            begin
                if (digit_cnt_reg == 2'd0 || comp_idx_reg == COMP_PATCH)
                    err_next = 1'b1;
                else
                begin
                    if (comp_idx_reg == COMP_MAJOR)
                        major_next = accum_reg;
                    else
                        minor_next = accum_reg;
                    comp_idx_next   = comp_idx_reg + 2'd1;
                    accum_next      = '0;
                    digit_cnt_next  = 2'd0;
                    first_zero_next = 1'b0;
                end
            end
            else
                err_next = 1'b1;
        end
    end

    // verdict on the final character, taken from the updated state
    assign ok = !err_next && comp_idx_next == COMP_PATCH && digit_cnt_next != 2'd0;

    always_comb
    begin
        if (major_next != ref_major_reg)
            newer = major_next > ref_major_reg;
        else if (minor_next != ref_minor_reg)
            newer = minor_next > ref_minor_reg;
        else
            newer = accum_next > ref_patch_reg;
    end

    assign out_valid_next = (proc && last_reg) ? 1'b1 :
                            (m_tready ? 1'b0 : out_valid_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_major_reg  <= '0;
            ref_minor_reg  <= '0;
            ref_patch_reg  <= '0;
            in_valid_reg   <= 1'b0;
            at_start_reg   <= 1'b1;
            comp_idx_reg   <= 2'd0;
            accum_reg      <= '0;
            digit_cnt_reg  <= 2'd0;
            first_zero_reg <= 1'b0;
            err_reg        <= 1'b0;
            major_reg      <= '0;
            minor_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // reference writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_REF_MAJOR: ref_major_reg <= cfg_wdata;
                    CFG_REF_MINOR: ref_minor_reg <= cfg_wdata;
                    CFG_REF_PATCH: ref_patch_reg <= cfg_wdata;
                    default:       ;
                endcase
            end

            if (s_tready)
                in_valid_reg <= s_tvalid;

            // parse state, cleared after the final character
            if (proc && last_reg)
            begin
                at_start_reg   <= 1'b1;
                comp_idx_reg   <= 2'd0;
                accum_reg      <= '0;
                digit_cnt_reg  <= 2'd0;
                first_zero_reg <= 1'b0;
                err_reg        <= 1'b0;
                major_reg      <= '0;
                minor_reg      <= '0;
            end
            else
            begin
                at_start_reg   <= at_start_next;
                comp_idx_reg   <= comp_idx_next;
                accum_reg      <= accum_next;
                digit_cnt_reg  <= digit_cnt_next;
                first_zero_reg <= first_zero_next;
                err_reg        <= err_next;
                major_reg      <= major_next;
                minor_reg      <= minor_next;
            end

            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (proc && last_reg)
        begin
            res_ok_reg    <= ok;
            res_major_reg <= ok ? major_next : '0;
            res_minor_reg <= ok ? minor_next : '0;
            res_patch_reg <= ok ? accum_next : '0;
            res_newer_reg <= ok && newer;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, res_newer_reg, res_patch_reg, res_minor_reg,
                       res_major_reg, res_ok_reg};

    // checks
    a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
        comp_idx_reg != 2'd3)
        else $error("component index out of range");

    a_digit_sat: assert property (@(posedge clk) disable iff (!rst_n)
        digit_cnt_reg != 2'd3)
        else $error("digit count past saturation");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        proc && last_reg |=> at_start_reg && !err_reg && m_tvalid)
        else $error("parse state not restarted after final character");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata == '0)
        else $error("invalid result carries nonzero fields");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word overwritten while stalled");

endmodule : dotted_version_parser_core

`default_nettype wire

[tb/sv/dotted_version_parser_core_tb.sv]
// dotted_version_parser_core_tb: self-checking bench for the dotted version parser
// streams directed and random version strings, predicts each result word in a scoreboard
// depends on dvp_pkg and dotted_version_parser_core
`default_nettype none

module dotted_version_parser_core_tb
    import dvp_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 6;
    localparam int IDLE_PCT = 29;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // result word as laid out on m_tdata, lowest field last
    typedef struct packed {
        logic [5:0]  pad;
        logic        newer;
        logic [31:0] patch;
        logic [31:0] minor;
        logic [31:0] major;
        logic        ok;
    } ver_word_t;

    // tracks the parse of the character stream and holds expected result words
    class version_scoreboard;
        logic [31:0] ref_val [3];
        bit          fresh;
        logic [1:0]  part;
        logic [31:0] cur;
        logic [1:0]  ndig;
        bit          lead_zero;
        bit          bad;
        logic [31:0] major_done;
        logic [31:0] minor_done;
        ver_word_t   expected_words [$];
        int          chars_seen;
        int          words_checked;
        int          newer_seen;
        int          invalid_seen;
        int          faults;

        function new();
            foreach (ref_val[i]) ref_val[i] = '0;
            chars_seen = 0;
            words_checked = 0;
            newer_seen = 0;
            invalid_seen = 0;
            faults = 0;
            restart();
        endfunction

        function void restart();
            fresh = 1'b1;
            part = COMP_MAJOR;
            cur = '0;
            ndig = '0;
            lead_zero = 1'b0;
            bad = 1'b0;
            major_done = '0;
            minor_done = '0;
        endfunction

        function void set_ref(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_REF_MAJOR: ref_val[0] = val;
                CFG_REF_MINOR: ref_val[1] = val;
                CFG_REF_PATCH: ref_val[2] = val;
                default: ;
            endcase
        endfunction

        // advance the parse by one accepted character word
        function void note_char(logic [7:0] ch, logic last);
            bit          was_first;
            logic [3:0]  digit;
            logic [63:0] grown;
            ver_word_t   w;
            was_first = fresh;
            fresh = 1'b0;
            chars_seen++;
            if (!bad && !(was_first && ch == CH_V)) begin
                if (ch >= CH_ZERO && ch <= CH_NINE) begin
                    digit = 4'(ch - CH_ZERO);
                    grown = 64'(cur) * 64'd10 + 64'(digit);
                    if ((ndig != 0 && lead_zero) || grown > 64'(ALL_ONES))
                        bad = 1'b1;
                    else
                    begin
                        if (ndig == 0)
                            lead_zero = (digit == 0);
                        cur = grown[31:0];
                        if (ndig != DIGITS_MANY)
                            ndig++;
                    end
                end
                else if (ch == CH_DOT) begin
                    if (ndig == 0 || part == COMP_PATCH)
                        bad = 1'b1;
                    else
                    begin
                        if (part == COMP_MAJOR)
                            major_done = cur;
                        else
                            minor_done = cur;
                        part++;
                        cur = '0;
                        ndig = '0;
                        lead_zero = 1'b0;
                    end
                end
                else
                    bad = 1'b1;
            end
            if (last) begin
                w = '0;
                if (!bad && part == COMP_PATCH && ndig != 0) begin
                    w.ok = 1'b1;
                    w.major = major_done;
                    w.minor = minor_done;
                    w.patch = cur;
                    // lexicographic compare major, minor, patch
                    w.newer = {major_done, minor_done, cur} >
                              {ref_val[0], ref_val[1], ref_val[2]};
                end
                expected_words.insert(expected_words.size(), w);
                restart();
            end
        endfunction

        // compare one result word with the oldest expectation
        function void check_word(ver_word_t got);
            ver_word_t want;
            if (expected_words.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result word %h", got);
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (want.newer) newer_seen++;
            if (!want.ok) invalid_seen++;
            if (got.ok !== want.ok || got.major !== want.major || got.minor !== want.minor
                || got.patch !== want.patch || got.newer !== want.newer || got.pad !== '0) begin
                faults++;
                if (faults <= 10) begin
                    $display("mismatch on result %0d: expected ok=%0b %0d.%0d.%0d newer=%0b",
                             words_checked, want.ok, want.major, want.minor, want.patch,
                             want.newer);
                    $display("    got ok=%0b %0d.%0d.%0d newer=%0b pad=%h",
                             got.ok, got.major, got.minor, got.patch, got.newer, got.pad);
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VAL_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CHAR_W-1:0]    s_tdata = '0;     // [7:0] char_in
    logic                 s_tlast = 1'b0;   // last_char
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;          // [0] valid_res, [32:1] major, [64:33] minor,
                                            // [96:65] patch, [97] newer, [103:98] zero

    version_scoreboard sb = new();
    logic [7:0] text [$];
    bit         steady = 1'b0;
    int         settings_run = 0;
    int         cycles = 0;

    dotted_version_parser_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("dotted_version_parser_core_tb: errors");
            $finish;
        end
    end

    function automatic bit idle_roll();
        return !steady && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // append one character to the string under construction
    function automatic void add_char(logic [7:0] ch);
        text.insert(text.size(), ch);
    endfunction

    // result side: check accepted words, stall at random
    initial
    begin
        forever begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready)
                sb.check_word(ver_word_t'(m_tdata));
            m_tready <= !idle_roll();
        end
    end

    // one character word, with random idle cycles ahead of it
    task automatic send_char(logic [7:0] ch, logic last);
        while (idle_roll()) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tlast <= last;
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.note_char(ch, last);
    endtask

    task automatic send_string();
        foreach (text[i])
            send_char(text[i], i == text.size() - 1);
    endtask

    task automatic run_text(string s);
        text.delete();
        for (int i = 0; i < s.len(); i++)
            add_char(8'(s[i]));
        send_string();
    endtask

    // wait for every expected word, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        do @(posedge clk); while (sb.expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all reference registers plus the unused index
    task automatic write_refs(logic [31:0] maj, logic [31:0] mnr, logic [31:0] pat);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [31:0]          val [4];
        idx = '{CFG_REF_MAJOR, CFG_REF_MINOR, CFG_REF_PATCH, CFG_SPARE};
        val = '{maj, mnr, pat, $urandom};
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
            sb.set_ref(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic put_num(logic [63:0] v);
        logic [7:0] rev [$];
        do begin
            rev.insert(rev.size(), CH_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        while (rev.size() != 0)
            add_char(rev.pop_back());
    endtask

    // component values clustered around the reference so newer flips both ways
    function automatic logic [31:0] near_value(logic [31:0] base);
        case ($urandom_range(0, 9))
            0, 1, 2: return base;
            3:       return base + 1;
            4:       return base - 1;
            5:       return '0;
            6:       return $urandom_range(0, 9);
            7:       return $urandom_range(10, 999);
            8:       return $urandom;
            default: return ALL_ONES;
        endcase
    endfunction

    // random string: mostly well formed, the rest broken or noise
    task automatic make_string();
        int kind;
        int lz;
        int big;
        int pos;
        kind = $urandom_range(0, 99);
        text.delete();
        if (kind >= 92) begin
            repeat ($urandom_range(1, 6))
                add_char(8'($urandom_range(0, 255)));
        end
        else
        begin
            lz = (kind >= 70 && kind < 75) ? $urandom_range(0, 2) : 3;
            big = (kind >= 75 && kind < 79) ? $urandom_range(0, 2) : 3;
            if ($urandom_range(0, 1))
                add_char(CH_V);
            for (int k = 0; k < 3; k++) begin
                if (k != 0) begin
                    add_char(CH_DOT);
                    // empty component
                    if (kind >= 85 && kind < 88 && k == 2 - (kind % 2))
                        add_char(CH_DOT);
                end
                if (k == lz)
                    add_char(CH_ZERO);
                if (k == big)
                    put_num({28'd0, 4'($urandom_range(1, 15)), 32'($urandom)});
                else
                    put_num(64'(near_value(sb.ref_val[k])));
            end
            // fourth component
            if (kind >= 79 && kind < 82) begin
                add_char(CH_DOT);
                put_num(64'($urandom_range(0, 99)));
            end
            // truncated string
            if (kind >= 82 && kind < 85) begin
                pos = $urandom_range(1, text.size() - 1);
                while (text.size() > pos)
                    void'(text.pop_back());
            end
            // one character replaced by an arbitrary byte
            if (kind >= 88)
                text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endtask

    task automatic run_phase(logic [31:0] maj, logic [31:0] mnr, logic [31:0] pat,
                             int budget, bit quiet);
        int start;
        write_refs(maj, mnr, pat);
        settings_run++;
        steady = quiet;
        start = sb.chars_seen;
        while (sb.chars_seen - start < budget) begin
            make_string();
            send_string();
        end
        drain();
        steady = 1'b0;
    endtask

    // main sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings against the reset reference 0.0.0
        settings_run++;
        run_text("v");
        run_text("0.0.0");
        run_text("v1.2.3");
        run_text("4294967295.4294967295.4294967295");
        run_text("4294967296.0.0");
        run_text("1.2");
        run_text("1..2");
        run_text("01.2.3");
        run_text("1.2.3.4");
        run_text("vv1.2.3");
        run_text("1.2.3v");
        run_text(".");
        run_text("0.0.1");
        drain();

        // reference settings, extremes among them; one phase with no idling
        run_phase(32'd1, 32'd2, 32'd3, 300, 1'b0);
        run_phase(ALL_ONES, ALL_ONES, ALL_ONES, 300, 1'b0);
        run_phase($urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20),
                  300, 1'b1);
        run_phase($urandom, $urandom, $urandom, 300, 1'b0);
        run_phase(32'd0, 32'd0, 32'd0, 300, 1'b0);
        run_phase(32'd7, 32'd0, ALL_ONES, 300, 1'b0);

        $display("sent %0d characters under %0d reference settings", sb.chars_seen,
                 settings_run);
        $display("checked %0d results: %0d newer, %0d invalid, %0d faults", sb.words_checked,
                 sb.newer_seen, sb.invalid_seen, sb.faults);
        if (sb.faults == 0 && sb.expected_words.size() == 0)
            $display("dotted_version_parser_core_tb: clean");
        else
            $display("dotted_version_parser_core_tb: errors");
        $finish;
    end

endmodule : dotted_version_parser_core_tb

`default_nettype wire
